@@ sv/permutation_rank_encoder_defines.svh @@
// Assertion macros used by the permutation rank encoder top level.
`ifndef PERMUTATION_RANK_ENCODER_DEFINES_SVH
`define PERMUTATION_RANK_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset.
`define PRE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pre assertion failed");

// Implication whose consequent is checked in the next cycle, outside reset.
`define PRE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pre assertion failed");

`else

`define PRE_ASSERT(lbl, clk, rst_n, prop)
`define PRE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop)

`endif

`endif

@@ sv/pre_pkg.sv @@
// Package: widths, defaults, control structs and FSM type of the rank encoder.
`timescale 1ns / 1ps
`default_nettype none

package pre_pkg;

    localparam int ELEM_W         = 8;   // element_value field
    localparam int RANK_W         = 45;  // perm_rank field
    localparam int LEN_W          = 5;   // perm_length field
    localparam int MAX_LEN_DEF    = 16;
    localparam int VALUE_BITS_DEF = 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Per-cycle control of the cell chain.
    typedef struct packed {
        logic shift;  // every cell takes its left neighbor's contents
        logic load;   // new element enters; held values compare against it
    } t_cell_ctl;

    // Control of the Horner accumulator.
    typedef struct packed {
        logic start;  // clear rank, load remaining length
        logic step;   // rank = rank * remaining + count
    } t_horner_ctl;

endpackage

`default_nettype wire

@@ sv/pre_ifs.sv @@
// Valid/ready channel interfaces for element input and rank output words.
`timescale 1ns / 1ps
`default_nettype none

interface pre_in_if;
    import pre_pkg::*;

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_value;
    logic              last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface pre_out_if;
    import pre_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] perm_rank;
    logic [LEN_W-1:0]  perm_length;
    logic              length_overflow;

    modport source (output valid, output perm_rank, output perm_length,
                    output length_overflow, input ready);
    modport sink   (input valid, input perm_rank, input perm_length,
                    input length_overflow, output ready);
endinterface

`default_nettype wire

@@ sv/pre_cell.sv @@
// One cell of the chain: holds an element and its count of smaller later elements.
`timescale 1ns / 1ps
`default_nettype none

module pre_cell #(
    parameter int VALUE_BITS = pre_pkg::VALUE_BITS_DEF,
    parameter int CW         = 4
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire pre_pkg::t_cell_ctl     i_ctl,
    input  wire [VALUE_BITS-1:0]        i_elem,
    input  wire                         i_prev_valid,
    input  wire [VALUE_BITS-1:0]        i_prev_value,
    input  wire [CW-1:0]                i_prev_count,
    output logic                        o_valid,
    output logic [VALUE_BITS-1:0]       o_value,
    output logic [CW-1:0]               o_count
);
    import pre_pkg::*;

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic [CW-1:0]         r_count;
    logic                  w_gt;

    // held element greater than the arriving one: one more smaller element after it
    assign w_gt = i_ctl.load & r_valid & (r_value > i_elem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_prev_value;
            r_count <= i_prev_count;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_count = r_count + CW'(w_gt);

endmodule

`default_nettype wire

@@ sv/pre_horner.sv @@
// Horner accumulator: rank = rank*rem + count per cycle with step high.
`timescale 1ns / 1ps
`default_nettype none

module pre_horner #(
    parameter int LW = 5,
    parameter int CW = 4
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire pre_pkg::t_horner_ctl  i_ctl,
    input  wire [LW-1:0]               i_length,
    input  wire [CW-1:0]               i_count,
    output logic [pre_pkg::RANK_W-1:0] o_rank,
    output logic [LW-1:0]              o_rem
);
    import pre_pkg::*;

    logic [RANK_W-1:0]    r_rank;
    logic [LW-1:0]        r_rem;
    logic [RANK_W+LW-1:0] w_prod;
    logic [RANK_W-1:0]    n_rank;

    assign w_prod = r_rank * r_rem;
    assign n_rank = w_prod[RANK_W-1:0] + RANK_W'(i_count);  // modulo 2^RANK_W

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_ctl.start) begin
            r_rem <= i_length;
        end else if (i_ctl.step) begin
            r_rem <= r_rem - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rank <= '0;
        end else if (i_ctl.step) begin
            r_rank <= n_rank;
        end
    end

    assign o_rank = r_rank;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ sv/permutation_rank_encoder.sv @@
// Top level: permutation rank encoder built from a chain of element cells.
//
//  channel | dir | word                                         | handshake
//  --------+-----+----------------------------------------------+----------
//  i_in    | in  | element_value, last_element                  | valid/ready
//  o_out   | out | perm_rank, perm_length, length_overflow      | valid/ready
//
// Elements load at one per cycle while in ST_LOAD; each shifts into cell 0
// while older cells move one place down the chain and update their counts
// on the way. A last element starts a drain (the chain shifts out at its
// far end, one Horner step per valid cell); ST_DONE then hands the result
// to the output register, and only after that write is the next element
// accepted.
// Synchronous active-low reset empties the chain and the output register.
// A stalled output only holds the encoder once the next result is ready.
`timescale 1ns / 1ps
`default_nettype none

`include "permutation_rank_encoder_defines.svh"

module permutation_rank_encoder #(
    parameter int MAX_LEN    = pre_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = pre_pkg::VALUE_BITS_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    pre_in_if.sink    i_in,
    pre_out_if.source o_out
);
    import pre_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);               // fill count 0..MAX_LEN
    localparam int CW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;  // count 0..MAX_LEN-1

    // ---------------- control state ----------------
    t_state         r_state, n_state;
    logic [LW-1:0]  r_fill, n_fill;
    logic           r_ovf;

    // ---------------- output register ----------------
    logic              r_out_valid;
    logic [RANK_W-1:0] r_out_rank;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_ovf;

    // ---------------- FSM outputs ----------------
    logic        w_in_ready;
    t_cell_ctl   w_cell_ctl;
    t_horner_ctl w_hctl;
    logic        w_out_write;

    logic                  w_accept;
    logic                  w_full;
    logic [VALUE_BITS-1:0] w_elem;

    // chain taps
    logic                  w_valid [MAX_LEN];
    logic [VALUE_BITS-1:0] w_value [MAX_LEN];
    logic [CW-1:0]         w_count [MAX_LEN];
    logic [MAX_LEN-1:0]    w_valid_vec;

    logic [RANK_W-1:0] w_rank;
    logic [LW-1:0]     w_rem;
    logic              w_tail_valid;

    assign w_accept     = i_in.valid & w_in_ready;
    assign w_full       = (r_fill == LW'(MAX_LEN));
    assign w_tail_valid = w_valid[MAX_LEN-1];

    // the element's low VALUE_BITS bits take part; a narrower one is zero-extended
    if (VALUE_BITS <= ELEM_W) begin : g_elem_trunc
        assign w_elem = i_in.element_value[VALUE_BITS-1:0];
    end else begin : g_elem_ext
        assign w_elem = {{(VALUE_BITS - ELEM_W){1'b0}}, i_in.element_value};
    end

    // fill after this word; an element beyond MAX_LEN is dropped
    assign n_fill = (w_accept && !w_full) ? r_fill + LW'(1) : r_fill;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_in.last_element) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                // last Horner step: newest element sits at the chain end
                if (w_tail_valid && (w_rem == LW'(1))) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_write) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // ---------------- FSM outputs ----------------
    always_comb begin
        w_in_ready       = 1'b0;
        w_cell_ctl.shift = 1'b0;
        w_cell_ctl.load  = 1'b0;
        w_hctl.start     = 1'b0;
        w_hctl.step      = 1'b0;
        w_out_write      = 1'b0;
        case (r_state)
            ST_LOAD: begin
                w_in_ready       = 1'b1;
                w_cell_ctl.load  = i_in.valid & !w_full;
                w_cell_ctl.shift = i_in.valid & !w_full;
                w_hctl.start     = i_in.valid & i_in.last_element;
            end
            ST_DRAIN: begin
                w_cell_ctl.shift = 1'b1;
                w_hctl.step      = w_tail_valid;
            end
            ST_DONE: begin
                w_out_write = !r_out_valid | o_out.ready;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_write) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_fill <= n_fill;
                if (w_accept && w_full) r_ovf <= 1'b1;
            end
            if (w_out_write) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_write) begin
            r_out_rank <= w_rank;
            r_out_len  <= LEN_W'(r_fill);
            r_out_ovf  <= r_ovf;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        logic                  w_in_valid;
        logic [VALUE_BITS-1:0] w_in_value;
        logic [CW-1:0]         w_in_count;

        if (k == 0) begin : g_head
            // new element enters with a zero count; empty slots enter while draining
            assign w_in_valid = w_cell_ctl.load;
            assign w_in_value = w_elem;
            assign w_in_count = '0;
        end else begin : g_link
            assign w_in_valid = w_valid[k-1];
            assign w_in_value = w_value[k-1];
            assign w_in_count = w_count[k-1];
        end

        pre_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CW         (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_cell_ctl),
            .i_elem       (w_elem),
            .i_prev_valid (w_in_valid),
            .i_prev_value (w_in_value),
            .i_prev_count (w_in_count),
            .o_valid      (w_valid[k]),
            .o_value      (w_value[k]),
            .o_count      (w_count[k])
        );

        assign w_valid_vec[k] = w_valid[k];
    end

    // ---------------- Horner accumulator ----------------
    pre_horner #(
        .LW (LW),
        .CW (CW)
    ) u_horner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_hctl),
        .i_length (n_fill),
        .i_count  (w_count[MAX_LEN-1]),
        .o_rank   (w_rank),
        .o_rem    (w_rem)
    );

    // ---------------- output port ----------------
    assign i_in.ready            = w_in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.perm_rank       = r_out_rank;
    assign o_out.perm_length     = r_out_len;
    assign o_out.length_overflow = r_out_ovf;

    // ---------------- assertions ----------------
    // while loading, occupied cells track the fill count
    `PRE_ASSERT(a_fill_matches_cells, i_clk, i_rst_n,
        (r_state == ST_LOAD) |-> ($countones(w_valid_vec) == 32'(r_fill)))
    // a Horner step never runs with nothing left to fold in
    `PRE_ASSERT(a_step_has_rem, i_clk, i_rst_n, w_hctl.step |-> (w_rem != '0))
    // a last element always starts the drain
    `PRE_ASSERT_NEXT(a_last_starts_drain, i_clk, i_rst_n,
        w_accept && i_in.last_element, r_state == ST_DRAIN)
    // a result word never reports an empty permutation
    `PRE_ASSERT(a_out_len_nonzero, i_clk, i_rst_n, r_out_valid |-> (r_out_len != '0))

endmodule

`default_nettype wire

@@ tb/tb_permutation_rank_encoder.sv @@
// Self-checking testbench for the permutation rank encoder (Lehmer code rank).
`timescale 1ns / 1ps

module tb_permutation_rank_encoder;
    import pre_pkg::*;

    localparam int MAX_LEN      = MAX_LEN_DEF;
    localparam int VALUE_BITS   = VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic [ELEM_W-1:0] VALUE_MASK = ELEM_W'((64'd1 << VALUE_BITS) - 1);

    // One output word as the block should present it.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [LEN_W-1:0]  len;
        logic              ovf;
    } rank_word_t;

    // Directed stimulus row; typed rows carry a hand-written expected word.
    typedef struct {
        logic [ELEM_W-1:0] elem;
        logic              last;
        bit                typed;
        rank_word_t        want;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    pre_in_if  in_ch ();
    pre_out_if out_ch ();

    permutation_rank_encoder #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: held elements, smaller-later counts, fill level.
    logic [ELEM_W-1:0] cell_val [MAX_LEN];
    logic [3:0]        cell_cnt [MAX_LEN];
    logic [4:0]        cells_used;
    logic              over_seen;

    rank_word_t expected_ranks [$];
    stim_row_t  directed_rows [$];
    int         rank_errors;
    int         burst_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Absorb one accepted element; on a last mark, form the rank by Horner
    // steps and return to the empty state.
    task automatic lehmer_step(input logic [ELEM_W-1:0] elem, input logic last_mark,
                               output bit emitted, output rank_word_t word);
        logic [ELEM_W-1:0] v;
        logic [RANK_W-1:0] acc;
        int                k;
        v       = elem & VALUE_MASK;
        emitted = 1'b0;
        word    = '0;
        if (cells_used < MAX_LEN) begin
            for (k = 0; k < cells_used; k++) begin
                if (cell_val[k] > v) cell_cnt[k]++;
            end
            cell_val[cells_used] = v;
            cell_cnt[cells_used] = '0;
            cells_used++;
        end else begin
            over_seen = 1'b1;   // element beyond capacity is dropped
        end
        if (last_mark) begin
            acc = '0;
            for (k = 0; k < cells_used; k++) begin
                acc = acc * RANK_W'(cells_used - k) + RANK_W'(cell_cnt[k]);
            end
            word.rank  = acc;
            word.len   = cells_used;
            word.ovf   = over_seen;
            emitted    = 1'b1;
            cells_used = '0;
            over_seen  = 1'b0;
            for (k = 0; k < MAX_LEN; k++) cell_cnt[k] = '0;
        end
    endtask

    function automatic void add_row(input logic [ELEM_W-1:0] e, input logic l, input bit t,
                                    input logic [RANK_W-1:0] r, input logic [LEN_W-1:0] n,
                                    input logic o);
        stim_row_t row;
        row.elem      = e;
        row.last      = l;
        row.typed     = t;
        row.want.rank = r;
        row.want.len  = n;
        row.want.ovf  = o;
        directed_rows.push_back(row);
    endfunction

    // Drive one word from a falling edge, hold it until accepted, then
    // record the expectation. Bursts end in a gap with valid low.
    task automatic send_word(input logic [ELEM_W-1:0] elem, input logic last_mark,
                             input bit use_typed, input rank_word_t typed_word);
        bit         emitted;
        rank_word_t predicted;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        in_ch.valid         <= 1'b1;
        in_ch.element_value <= elem;
        in_ch.last_element  <= last_mark;
        do @(posedge i_clk); while (!in_ch.ready);
        lehmer_step(elem, last_mark, emitted, predicted);
        if (emitted) expected_ranks.push_back(use_typed ? typed_word : predicted);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Receiver: ready pattern switches at random between free flow,
    // coin flip and mostly stalled.
    int ready_mode;
    int mode_left;
    initial begin
        ready_mode = 0;
        mode_left  = 0;
    end
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(10, 80);
        end
        mode_left--;
        case (ready_mode)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                out_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // Output checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin : rank_check
        rank_word_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_ranks.size() == 0) begin
                $error("unexpected output word: perm_rank %0d perm_length %0d",
                       out_ch.perm_rank, out_ch.perm_length);
                rank_errors++;
            end else begin
                want = expected_ranks.pop_front();
                if (out_ch.perm_rank !== want.rank) begin
                    $error("perm_rank: expected %0d, got %0d", want.rank, out_ch.perm_rank);
                    rank_errors++;
                end
                if (out_ch.perm_length !== want.len) begin
                    $error("perm_length: expected %0d, got %0d", want.len, out_ch.perm_length);
                    rank_errors++;
                end
                if (out_ch.length_overflow !== want.ovf) begin
                    $error("length_overflow: expected %0d, got %0d",
                           want.ovf, out_ch.length_overflow);
                    rank_errors++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [ELEM_W-1:0] perm_buf [$];
        bit   [255:0]      taken;
        logic [ELEM_W-1:0] cand;
        int                items_sent;
        int                plen;
        int                kind;
        int                dup_mode;
        int                k;
        int                drain_cycles;

        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.element_value = '0;
        in_ch.last_element  = 1'b0;
        out_ch.ready        = 1'b0;
        rank_errors         = 0;
        burst_left          = 0;
        cells_used          = '0;
        over_seen           = 1'b0;
        for (k = 0; k < MAX_LEN; k++) begin
            cell_val[k] = '0;
            cell_cnt[k] = '0;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: single elements at both extremes, a two-element
        // inversion, equal values, a scrambled triple, then a full
        // descending run (largest rank) with one ignored element past
        // capacity that carries the last mark.
        add_row(8'd255, 1'b1, 1'b1, '0, 5'd1, 1'b0);
        add_row(8'd0,   1'b1, 1'b1, '0, 5'd1, 1'b0);
        add_row(8'd255, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'd0,   1'b1, 1'b1, 45'd1, 5'd2, 1'b0);
        add_row(8'd7,   1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'd7,   1'b1, 1'b1, '0, 5'd2, 1'b0);
        add_row(8'd3,   1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'd1,   1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'd2,   1'b1, 1'b0, '0, '0, 1'b0);
        for (k = 0; k < MAX_LEN; k++) begin
            add_row(ELEM_W'(255 - 17 * k), 1'b0, 1'b0, '0, '0, 1'b0);
        end
        add_row(8'd128, 1'b1, 1'b1, 45'd20922789887999, 5'd16, 1'b1);

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].elem, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].want);
        end

        // Random part: mostly distinct-valued permutations of random length,
        // some at or past capacity, some with repeated values.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)     plen = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
            else if (kind < 3) plen = $urandom_range(MAX_LEN - 2, MAX_LEN);
            else               plen = $urandom_range(1, MAX_LEN);
            dup_mode = $urandom_range(0, 5);   // 0: narrow repeats, 1: wide repeats
            perm_buf.delete();
            taken = '0;
            while (perm_buf.size() < plen) begin
                cand = (dup_mode == 0) ? ELEM_W'($urandom_range(0, 7))
                                       : ELEM_W'($urandom_range(0, 255));
                if (dup_mode < 2 || !taken[cand]) begin
                    taken[cand] = 1'b1;
                    perm_buf.push_back(cand);
                end
            end
            for (k = 0; k < plen; k++) begin
                send_word(perm_buf[k], (k == plen - 1), 1'b0, '0);
            end
            items_sent += (plen > MAX_LEN) ? MAX_LEN : plen;
        end
        in_ch.valid <= 1'b0;

        // Drain: wait for outstanding words, then a quiet stretch to catch
        // anything extra.
        drain_cycles = 0;
        while (expected_ranks.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (expected_ranks.size() != 0) begin
            $error("%0d output words never arrived", expected_ranks.size());
            rank_errors++;
        end
        repeat (4 * MAX_LEN + 8) @(posedge i_clk);

        if (rank_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/pre_pkg.sv
sv/pre_ifs.sv
sv/pre_cell.sv
sv/pre_horner.sv
sv/permutation_rank_encoder.sv
tb/tb_permutation_rank_encoder.sv
